// ===== hw/rtl/base64_line_wrapped_encoder_macros.svh =====
// assertion macros used by the checker file
`ifndef BASE64_LINE_WRAPPED_ENCODER_MACROS_SVH
`define BASE64_LINE_WRAPPED_ENCODER_MACROS_SVH

// implication checked at every clock edge outside reset
`define B64E_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequent is checked in the next cycle
`define B64E_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/b64e_pkg.sv =====
`default_nettype none

package b64e_pkg;

	localparam logic [7:0] LINE_LIMIT_RESET = 8'd72;
	localparam logic [7:0] NL_CHAR          = 8'h0A;
	localparam logic [7:0] PAD_CHAR         = 8'h3D;
	localparam int unsigned QUEUE_DEPTH     = 2;

	// one encoded group: four sextets, pad marks, trailing newline, end of message
	typedef struct packed {
		logic [3:0][5:0] sx;
		logic            pad2;
		logic            pad3;
		logic            nl;
		logic            last;
	} grp_t;

	// standard base64 alphabet
	function automatic logic [7:0] b64_sym(input logic [5:0] v);
		logic [7:0] ch;
		if (v < 6'd26) begin
			ch = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			ch = 8'h61 + {2'b00, v - 6'd26};
		end else if (v < 6'd62) begin
			ch = 8'h30 + {2'b00, v - 6'd52};
		end else if (v == 6'd62) begin
			ch = 8'h2B;
		end else begin
			ch = 8'h2F;
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/b64e_ifs.sv =====
`default_nettype none

interface b64e_raw_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;
	modport source (output valid, output out_char, output last_char, input ready);
	modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

interface b64e_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_limit;
	modport source (output valid, output line_limit, input ready);
	modport sink   (input valid, input line_limit, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/base64_line_wrapped_encoder.sv =====
// channel | dir | handshake     | payload
// raw     | in  | valid/ready   | data_byte[7:0], last_byte
// cfg     | in  | valid/ready   | line_limit[7:0] (ready always high)
// enc     | out | valid/ready   | out_char[7:0], last_char
//
// bytes are taken one per cycle while the group queue has room; the back end sends
// four characters per group, five when the group ends in a newline, so a one-byte
// message gives five characters
// with queue and back end idle, the first character of a group passes through the queue
// entry and then the output register before it is on enc
// arst_n clears fill, line count, queue and output valid; line_limit returns to 72
// a stall on enc holds the output register, fills the queue, then drops raw.ready
`default_nettype none

module base64_line_wrapped_encoder import b64e_pkg::*; #(
	parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	b64e_raw_if.sink   raw,
	b64e_cfg_if.sink   cfg,
	b64e_out_if.source enc
);

	// front end to queue
	logic q_push;
	grp_t q_grp;
	logic q_full;

	// queue to back end
	grp_t q_head;
	logic q_nonempty;
	logic q_pop;

	// front end: holds pending bytes, tracks line count, builds one group per
	// completed or final transaction
	b64e_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.cfg    (cfg),
		.q_full (q_full),
		.q_push (q_push),
		.q_grp  (q_grp)
	);

	// short group queue so either side can stall on its own
	b64e_queue #(
		.DEPTH (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_grp),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.nonempty  (q_nonempty)
	);

	// back end: turns each group into four characters plus an optional newline
	b64e_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.nonempty (q_nonempty),
		.pop      (q_pop),
		.enc      (enc)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/b64e_front.sv =====
`default_nettype none

module b64e_front import b64e_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	b64e_raw_if.sink    raw,
	b64e_cfg_if.sink    cfg,
	input  wire logic   q_full,
	output logic        q_push,
	output grp_t        q_grp
);

	logic [7:0] limit_q;
	logic [7:0] held0_q;
	logic [7:0] held1_q;
	logic [1:0] fill_q;
	logic [7:0] line_q;

	logic       accept;
	logic       full_grp;
	logic [8:0] sum;
	logic       wrap;
	logic [7:0] a0;
	logic [7:0] b;

	assign b        = raw.data_byte;
	assign raw.ready = !q_full;
	assign cfg.ready = 1'b1;
	assign accept   = raw.valid && !q_full;
	assign full_grp = fill_q[1];
	assign sum      = {1'b0, line_q} + 9'd4;
	assign wrap     = sum >= {1'b0, limit_q};
	assign a0       = (fill_q == 2'd0) ? b : held0_q;
	assign q_push   = accept && (full_grp || raw.last_byte);

	always_comb begin
		q_grp = '0;
		if (full_grp) begin
			q_grp.sx[0] = held0_q[7:2];
			q_grp.sx[1] = {held0_q[1:0], held1_q[7:4]};
			q_grp.sx[2] = {held1_q[3:0], b[7:6]};
			q_grp.sx[3] = b[5:0];
			q_grp.nl    = wrap || raw.last_byte;
			q_grp.last  = raw.last_byte;
		end else begin
			// partial group at end of message
			q_grp.sx[0] = a0[7:2];
			q_grp.sx[1] = {a0[1:0], (fill_q == 2'd0) ? 4'b0000 : b[7:4]};
			q_grp.sx[2] = {b[3:0], 2'b00};
			q_grp.pad2  = (fill_q == 2'd0);
			q_grp.pad3  = 1'b1;
			q_grp.nl    = 1'b1;
			q_grp.last  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LINE_LIMIT_RESET;
			fill_q  <= 2'd0;
			line_q  <= 8'd0;
		end else begin
			if (cfg.valid) begin
				limit_q <= cfg.line_limit;
			end
			if (accept) begin
				if (full_grp) begin
					fill_q <= 2'd0;
					line_q <= (wrap || raw.last_byte) ? 8'd0 : sum[7:0];
				end else if (raw.last_byte) begin
					fill_q <= 2'd0;
					line_q <= 8'd0;
				end else begin
					fill_q <= fill_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !full_grp && !raw.last_byte) begin
			if (fill_q[0]) begin
				held1_q <= b;
			end else begin
				held0_q <= b;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/b64e_queue.sv =====
`default_nettype none

module b64e_queue import b64e_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  grp_t      push_data,
	output logic      full,
	input  wire logic pop,
	output grp_t      head,
	output logic      nonempty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	grp_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= nxt(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= nxt(rd_ptr_q);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/b64e_back.sv =====
`default_nettype none

module b64e_back import b64e_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  grp_t       head,
	input  wire logic  nonempty,
	output logic       pop,
	b64e_out_if.source enc
);

	logic [2:0] idx_q;
	logic       valid_q;
	logic [7:0] char_q;
	logic       lastc_q;

	logic       advance;
	logic       load;
	logic [2:0] end_idx;
	logic       at_end;
	logic [7:0] ch;

	assign advance = !valid_q || enc.ready;
	assign load    = advance && nonempty;
	assign end_idx = head.nl ? 3'd4 : 3'd3;
	assign at_end  = (idx_q == end_idx);
	assign pop     = load && at_end;

	always_comb begin
		unique case (idx_q)
			3'd0:    ch = b64_sym(head.sx[0]);
			3'd1:    ch = b64_sym(head.sx[1]);
			3'd2:    ch = head.pad2 ? PAD_CHAR : b64_sym(head.sx[2]);
			3'd3:    ch = head.pad3 ? PAD_CHAR : b64_sym(head.sx[3]);
			default: ch = NL_CHAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 3'd0;
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= nonempty;
			if (nonempty) begin
				idx_q <= at_end ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q  <= ch;
			lastc_q <= head.last && at_end;
		end
	end

	assign enc.valid     = valid_q;
	assign enc.out_char  = char_q;
	assign enc.last_char = lastc_q;

endmodule

`default_nettype wire

// ===== hw/rtl/b64e_checker.sv =====
`default_nettype none
`include "base64_line_wrapped_encoder_macros.svh"

module b64e_checker import b64e_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       enc_valid,
	input wire logic       enc_ready,
	input wire logic [7:0] out_char,
	input wire logic       last_char
);

	logic prev_pad_q;
	logic enc_acc;

	assign enc_acc = enc_valid && enc_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pad_q <= 1'b0;
		end else if (enc_acc) begin
			prev_pad_q <= (out_char == PAD_CHAR);
		end
	end

	`B64E_ASSERT_NXT(a_enc_hold, enc_valid && !enc_ready, enc_valid, "enc valid dropped")
	`B64E_ASSERT_IMP(a_last_nl, enc_valid && last_char, out_char == NL_CHAR, "last not newline")
	`B64E_ASSERT_IMP(a_pad_tail, enc_acc && prev_pad_q, (out_char == PAD_CHAR) || (out_char == NL_CHAR), "bad char after pad")

endmodule

bind base64_line_wrapped_encoder b64e_checker u_b64e_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.enc_valid (enc.valid),
	.enc_ready (enc.ready),
	.out_char  (enc.out_char),
	.last_char (enc.last_char)
);

`default_nettype wire

// ===== tb/base64_line_wrapped_encoder_test.sv =====
`default_nettype none

module base64_line_wrapped_encoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import b64e_pkg::*;

	// generous bound: every byte with five characters, each behind a long stall
	localparam int unsigned CYCLE_LIMIT   = 300_000;
	// quiet cycles before a register write and at the end of the run
	localparam int unsigned SETTLE_CYCLES = 12;

	// expected character stream of the encoder, rebuilt one byte at a time
	class char_stream_checker;
		typedef struct packed {
			logic [7:0] ch;
			logic       fin;
		} enc_char_t;

		logic [7:0] line_limit;
		logic [7:0] line_count;
		logic [7:0] held[2];
		logic [1:0] fill;
		enc_char_t  expected_chars[$];
		int unsigned mismatches;

		function new();
			line_limit = LINE_LIMIT_RESET;
			line_count = '0;
			held[0]    = '0;
			held[1]    = '0;
			fill       = '0;
			mismatches = 0;
		endfunction

		function void set_limit(input logic [7:0] v);
			line_limit = v;
		endfunction

		function int unsigned pending();
			return expected_chars.size();
		endfunction

		function logic [7:0] sextet_char(input logic [5:0] v);
			string alphabet_chars =
				"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
			return alphabet_chars[v];
		endfunction

		function void push_char(input logic [7:0] c);
			enc_char_t item;
			item.ch  = c;
			item.fin = 1'b0;
			expected_chars.push_back(item);
		endfunction

		function void note_byte(input logic [7:0] b, input logic fin);
			logic [8:0] sum;
			enc_char_t  tail;
			if (fill == 2'd2) begin
				// third byte closes the group
				push_char(sextet_char(held[0][7:2]));
				push_char(sextet_char({held[0][1:0], held[1][7:4]}));
				push_char(sextet_char({held[1][3:0], b[7:6]}));
				push_char(sextet_char(b[5:0]));
				fill = 2'd0;
				sum  = {1'b0, line_count} + 9'd4;
				if (sum >= {1'b0, line_limit}) begin
					push_char(NL_CHAR);
					line_count = '0;
				end else begin
					line_count = sum[7:0];
				end
			end else begin
				held[fill[0]] = b;
				fill = fill + 2'd1;
				if (fin) begin
					// partial group, padded
					push_char(sextet_char(held[0][7:2]));
					if (fill == 2'd1) begin
						push_char(sextet_char({held[0][1:0], 4'b0000}));
						push_char(PAD_CHAR);
					end else begin
						push_char(sextet_char({held[0][1:0], held[1][7:4]}));
						push_char(sextet_char({held[1][3:0], 2'b00}));
					end
					push_char(PAD_CHAR);
					fill       = 2'd0;
					line_count = line_count + 8'd4;
					if (line_count == 8'd0) begin
						line_count = 8'd4;
					end
				end
			end
			if (fin) begin
				if (line_count != 8'd0) begin
					push_char(NL_CHAR);
				end
				tail     = expected_chars.pop_back();
				tail.fin = 1'b1;
				expected_chars.push_back(tail);
				fill       = 2'd0;
				line_count = '0;
			end
		endfunction

		function void check_char(input logic [7:0] ch, input logic fin);
			enc_char_t want;
			if (expected_chars.size() == 0) begin
				if (mismatches < 10) begin
					$display("unexpected character 0x%02h last %0b", ch, fin);
				end
				mismatches++;
				return;
			end
			want = expected_chars.pop_front();
			if (ch !== want.ch || fin !== want.fin) begin
				if (mismatches < 10) begin
					if (ch !== want.ch) begin
						$display("out_char: expected 0x%02h got 0x%02h", want.ch, ch);
					end
					if (fin !== want.fin) begin
						$display("last_char: expected %0b got %0b (char 0x%02h)",
							want.fin, fin, want.ch);
					end
				end
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	b64e_raw_if raw_bus ();
	b64e_cfg_if cfg_bus ();
	b64e_out_if enc_bus ();

	char_stream_checker tracker;

	int unsigned cycle_count = 0;
	int unsigned steady_left = 0;
	int unsigned stall_left  = 0;
	int unsigned ready_roll;

	base64_line_wrapped_encoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw_bus),
		.cfg    (cfg_bus),
		.enc    (enc_bus)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run-away guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("base64_line_wrapped_encoder_test: errors");
			$finish;
		end
	end

	// output back-pressure: mostly ready, short and long stalls, and calm
	// stretches where neither side idles
	always @(posedge clk) begin
		if (!arst_n) begin
			enc_bus.ready <= 1'b0;
		end else if (steady_left != 0) begin
			steady_left <= steady_left - 1;
			enc_bus.ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			enc_bus.ready <= 1'b0;
		end else begin
			ready_roll = $urandom_range(0, 999);
			if (ready_roll < 5) begin
				steady_left <= $urandom_range(40, 200);
				enc_bus.ready <= 1'b1;
			end else if (ready_roll < 150) begin
				stall_left <= $urandom_range(0, 2);
				enc_bus.ready <= 1'b0;
			end else if (ready_roll < 170) begin
				stall_left <= $urandom_range(8, 30);
				enc_bus.ready <= 1'b0;
			end else begin
				enc_bus.ready <= 1'b1;
			end
		end
	end

	// every character transaction goes to the checker
	always @(posedge clk) begin
		if (arst_n && enc_bus.valid && enc_bus.ready) begin
			tracker.check_char(enc_bus.out_char, enc_bus.last_char);
		end
	end

	// sender gap: none during a calm stretch, otherwise mostly short
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (steady_left != 0) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			return 0;
		end else if (roll < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 25);
	endfunction

	function automatic logic [7:0] pick_byte();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			return 8'h00;
		end else if (roll < 20) begin
			return 8'hFF;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// mostly short messages, now and then one long enough to wrap lines
	function automatic int unsigned pick_length();
		if ($urandom_range(0, 9) < 7) begin
			return $urandom_range(1, 12);
		end
		return $urandom_range(13, 90);
	endfunction

	// one byte transaction; valid stays high when the next byte follows at once
	task automatic send_byte(input logic [7:0] data, input logic fin, input int unsigned gap);
		if (gap != 0) begin
			raw_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		raw_bus.valid     <= 1'b1;
		raw_bus.data_byte <= data;
		raw_bus.last_byte <= fin;
		do @(posedge clk); while (!raw_bus.ready);
		tracker.note_byte(data, fin);
	endtask

	// wait for all characters, then let held bytes settle inside the block
	task automatic quiesce();
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] v);
		cfg_bus.valid      <= 1'b1;
		cfg_bus.line_limit <= v;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		tracker.set_limit(v);
	endtask

	// random messages under one line limit; a cut-short phase leaves a message
	// open so the next limit applies to a line already in progress
	task automatic run_phase(input logic [7:0] limit, input int unsigned budget,
			input int unsigned first_len, input bit cut_short);
		int unsigned sent;
		int unsigned len;
		int unsigned k;
		quiesce();
		write_limit(limit);
		sent = 0;
		while (sent < budget) begin
			len = (first_len != 0 && sent == 0) ? first_len : pick_length();
			for (k = 0; k < len; k++) begin
				send_byte(pick_byte(), k == len - 1, pick_gap());
			end
			sent += len;
		end
		if (cut_short) begin
			len = $urandom_range(1, 8);
			for (k = 0; k < len; k++) begin
				send_byte(pick_byte(), 1'b0, pick_gap());
			end
		end
		raw_bus.valid <= 1'b0;
	endtask

	initial begin
		tracker = new();
		arst_n             = 1'b0;
		raw_bus.valid      = 1'b0;
		raw_bus.data_byte  = '0;
		raw_bus.last_byte  = 1'b0;
		cfg_bus.valid      = 1'b0;
		cfg_bus.line_limit = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset line limit: two single bytes, two bytes, full group alone
		send_byte(8'h00, 1'b1, pick_gap());
		send_byte(8'hFF, 1'b1, pick_gap());
		send_byte(8'hFF, 1'b0, pick_gap());
		send_byte(8'hFF, 1'b1, pick_gap());
		// all sextets 62, then group followed by a one-byte and a two-byte tail
		send_byte(8'hFB, 1'b0, pick_gap());
		send_byte(8'hEF, 1'b0, pick_gap());
		send_byte(8'hBE, 1'b1, pick_gap());
		send_byte(8'h00, 1'b0, pick_gap());
		send_byte(8'h10, 1'b0, pick_gap());
		send_byte(8'h83, 1'b0, pick_gap());
		send_byte(8'hFC, 1'b1, pick_gap());
		send_byte(8'h14, 1'b0, pick_gap());
		send_byte(8'hFB, 1'b0, pick_gap());
		send_byte(8'h9C, 1'b0, pick_gap());
		send_byte(8'h03, 1'b0, pick_gap());
		send_byte(8'hD9, 1'b1, pick_gap());
		raw_bus.valid <= 1'b0;

		// smallest limit: newline after every group, none extra at a closing group
		quiesce();
		write_limit(8'd4);
		send_byte(8'h4D, 1'b0, pick_gap());
		send_byte(8'h61, 1'b0, pick_gap());
		send_byte(8'h6E, 1'b1, pick_gap());
		send_byte(8'hA5, 1'b0, pick_gap());
		send_byte(8'h5A, 1'b0, pick_gap());
		send_byte(8'hC3, 1'b0, pick_gap());
		send_byte(8'h3C, 1'b1, pick_gap());
		raw_bus.valid <= 1'b0;

		// random part across several limits, widest line first
		run_phase(8'd252, 192, 192, 1'b1);
		run_phase(8'd4, 1, 0, 1'b1);
		run_phase(8'($urandom_range(5, 80)), 1, 0, 1'b1);
		run_phase(8'd72, 1, 0, 1'b0);

		quiesce();
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("base64_line_wrapped_encoder_test: clean");
		end else begin
			$display("base64_line_wrapped_encoder_test: errors");
		end
		$finish;
	end

endmodule

`default_nettype wire
